/* hw/rtl/id_free_list_allocator_macros.svh */
// Assertion macros shared by the allocator's checker.
`ifndef ID_FREE_LIST_ALLOCATOR_MACROS_SVH
`define ID_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDFL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("id allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IDFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("id allocator check failed");

`endif

/* hw/rtl/idfl_pkg.sv */
`default_nettype none

package idfl_pkg;

	// Pool size and the widths that follow from it.
	localparam int NUM_IDS = 8192;
	localparam int OFF_W   = (NUM_IDS > 2) ? $clog2(NUM_IDS) : 1;
	localparam int CNT_W   = $clog2(NUM_IDS + 1);

	// Fixed field widths.
	localparam int ID_W    = 16;
	localparam int STAT_W  = 2;
	localparam int OUT_W   = 24;

	// Operation codes carried on the input tuser.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef logic [OFF_W-1:0] off_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ID_W-1:0]  id_t;

	localparam cnt_t NUM_IDS_C = cnt_t'(NUM_IDS);

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	// Access to the free-offset stack.
	typedef struct packed {
		logic rd_en;
		off_t rd_idx;
		logic wr_en;
		off_t wr_idx;
		off_t wr_data;
	} stack_req_t;

	// Access to the allocation bitmap.
	typedef struct packed {
		logic rd_en;
		off_t rd_off;
		logic wr_en;
		off_t wr_off;
		logic wr_bit;
	} map_req_t;

endpackage

`default_nettype wire

/* hw/rtl/idfl_stack.sv */
`default_nettype none

module idfl_stack (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire idfl_pkg::stack_req_t req,
	output idfl_pkg::off_t           rd_data,
	output idfl_pkg::cnt_t           low_mark
);
	import idfl_pkg::*;

	off_t mem [NUM_IDS];
	off_t mem_rd_q;
	off_t fresh_val_q;
	logic fresh_q;
	cnt_t low_q;

	// Synchronous memory with separate read and write ports: one write and one read per cycle.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_q    <= mem[req.rd_idx];
			fresh_q     <= cnt_t'(req.rd_idx) < low_q;
			fresh_val_q <= off_t'(NUM_IDS - 1) - req.rd_idx;
		end
	end

	// Lowest depth the stack has ever reached. Entries below it were never
	// written; their initial contents are computed rather than read from memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= NUM_IDS_C;
		end else if (req.rd_en && (cnt_t'(req.rd_idx) < low_q)) begin
			low_q <= cnt_t'(req.rd_idx);
		end
	end

	assign rd_data  = fresh_q ? fresh_val_q : mem_rd_q;
	assign low_mark = low_q;

endmodule

`default_nettype wire

/* hw/rtl/idfl_map.sv */
`default_nettype none

module idfl_map (
	input  wire                    clk,
	input  wire idfl_pkg::map_req_t req,
	input  wire idfl_pkg::cnt_t    low_mark,
	output logic                   rd_bit
);
	import idfl_pkg::*;

	logic mem [NUM_IDS];
	logic mem_rd_q;
	logic written_q;
	cnt_t written_lim;

	// Every offset below this limit has been popped at least once, so its
	// bitmap entry has been written. Offsets at or above it read as clear.
	assign written_lim = NUM_IDS_C - low_mark;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_off] <= req.wr_bit;
		end
		if (req.rd_en) begin
			mem_rd_q  <= mem[req.rd_off];
			written_q <= cnt_t'(req.rd_off) < written_lim;
		end
	end

	assign rd_bit = written_q & mem_rd_q;

endmodule

`default_nettype wire

/* hw/rtl/id_free_list_allocator.sv */
// An accepted request is held in stage one, where the stack and bitmap
// memory reads are registered; its result then goes to the output register.
// A new request is taken only once stage one has handed its result on. The
// memories are read on accept and written back when stage one completes.
// Reset: asynchronous, active low. The pool is full and usable at once;
// no memory clearing pass is needed. base_id resets to 1.
`default_nettype none

module id_free_list_allocator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [15:0] cfg_wdata,       // base_id
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,    // [15:0] id_in
	input  wire  [0:0]  s_axis_tuser,    // [0] operation
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata     // [15:0] id_out, [17:16] status
);
	import idfl_pkg::*;

	id_t        base_q;
	cnt_t       count_q;
	logic       busy_s1;
	logic       op_s1;
	id_t        off_s1;
	logic       out_valid_q;
	id_t        out_id_q;
	status_t    out_status_q;

	stack_req_t stack_req;
	map_req_t   map_req;
	off_t       stack_rd;
	cnt_t       low_mark;
	logic       map_bit;

	logic       accept;
	logic       fire;
	logic       count_zero;
	id_t        in_off;
	logic       in_range;
	logic       free_ok;
	id_t        alloc_id;
	status_t    res_status;
	id_t        res_id;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign fire       = busy_s1 && (!out_valid_q || m_axis_tready);
	assign count_zero = (count_q == '0);
	assign in_off     = s_axis_tdata - base_q;

	// Base register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 16'd1;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// Result of the request held in stage one.
	assign in_range = off_s1 < ID_W'(NUM_IDS);
	assign free_ok  = in_range && map_bit && (count_q < NUM_IDS_C);
	assign alloc_id = base_q + ID_W'(stack_rd);

	always_comb begin
		if (op_s1 == OP_ALLOC) begin
			res_status = count_zero ? ST_EMPTY : ST_DONE;
			res_id     = count_zero ? '0 : alloc_id;
		end else begin
			res_status = free_ok ? ST_DONE : ST_IGNORED;
			res_id     = '0;
		end
	end

	// Memory reads on accept, write-back when stage one completes.
	always_comb begin
		stack_req         = '0;
		map_req           = '0;
		stack_req.rd_en   = accept && (s_axis_tuser[0] == OP_ALLOC) && !count_zero;
		stack_req.rd_idx  = OFF_W'(count_q - cnt_t'(1));
		map_req.rd_en     = accept && (s_axis_tuser[0] == OP_FREE);
		map_req.rd_off    = in_off[OFF_W-1:0];
		if (fire && (op_s1 == OP_ALLOC) && !count_zero) begin
			map_req.wr_en  = 1'b1;
			map_req.wr_off = stack_rd;
			map_req.wr_bit = 1'b1;
		end
		if (fire && (op_s1 == OP_FREE) && free_ok) begin
			map_req.wr_en     = 1'b1;
			map_req.wr_off    = off_s1[OFF_W-1:0];
			map_req.wr_bit    = 1'b0;
			stack_req.wr_en   = 1'b1;
			stack_req.wr_idx  = count_q[OFF_W-1:0];
			stack_req.wr_data = off_s1[OFF_W-1:0];
		end
	end

	idfl_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (stack_req),
		.rd_data  (stack_rd),
		.low_mark (low_mark)
	);

	idfl_map u_map (
		.clk      (clk),
		.req      (map_req),
		.low_mark (low_mark),
		.rd_bit   (map_bit)
	);

	// Stage one control and the free count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			count_q <= NUM_IDS_C;
		end else begin
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (fire) begin
				busy_s1 <= 1'b0;
			end
			if (fire && (op_s1 == OP_ALLOC) && !count_zero) begin
				count_q <= count_q - cnt_t'(1);
			end else if (fire && (op_s1 == OP_FREE) && free_ok) begin
				count_q <= count_q + cnt_t'(1);
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= s_axis_tuser[0];
			off_s1 <= in_off;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_id_q     <= res_id;
			out_status_q <= res_status;
		end
	end

	assign s_axis_tready = !busy_s1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_W - ID_W - STAT_W)'(0), out_status_q, out_id_q};

endmodule

`default_nettype wire

/* hw/rtl/idfl_checker.sv */
`default_nettype none

`include "id_free_list_allocator_macros.svh"

module idfl_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [23:0] m_axis_tdata
);
	import idfl_pkg::*;

	logic in_acc;
	logic out_stall;
	logic out_not_done;

	assign in_acc       = s_axis_tvalid && s_axis_tready;
	assign out_stall    = m_axis_tvalid && !m_axis_tready;
	assign out_not_done = m_axis_tvalid && (m_axis_tdata[17:16] != ST_DONE);

	// A stalled result keeps its contents.
	`IDFL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

	// Only one request is in flight in the processing stage.
	`IDFL_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_acc, !s_axis_tready)

	// A request taken while the output is free goes through stage one and the output register with no stall.
	`IDFL_ASSERT_NEXT(a_latency, clk, arst_n, in_acc && !m_axis_tvalid, ##1 m_axis_tvalid)

	// Only a completed request carries a nonzero identifier.
	`IDFL_ASSERT_IMPL(a_id_zero, clk, arst_n, out_not_done, m_axis_tdata[15:0] == 16'd0)

endmodule

bind id_free_list_allocator idfl_checker u_idfl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* verif/id_pool_checker.sv */
`default_nettype none

module id_pool_checker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire   [15:0] cfg_wdata,
	input  wire          s_axis_tvalid,
	input  wire          s_axis_tready,
	input  wire   [15:0] s_axis_tdata,    // [15:0] id_in
	input  wire   [0:0]  s_axis_tuser,    // [0] operation
	input  wire          m_axis_tvalid,
	input  wire          m_axis_tready,
	input  wire   [23:0] m_axis_tdata,    // [15:0] id_out, [17:16] status
	output int unsigned  mismatch_count,
	output int unsigned  replies_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import idfl_pkg::*;

	typedef struct packed {
		id_t     id;
		status_t status;
	} reply_t;

	// Shadow copy of the pool: free offsets as a stack, plus the handed-out map.
	off_t        free_offs [NUM_IDS];
	bit          handed_out [NUM_IDS];
	int unsigned free_count;
	id_t         pool_base;
	reply_t      replies_due [$];

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("%0t ns: mismatch: %s", $realtime, what);
	endtask

	task automatic reset_pool();
		for (int i = 0; i < NUM_IDS; i++) begin
			free_offs[i] = off_t'(NUM_IDS - 1 - i);
			handed_out[i] = 1'b0;
		end
		free_count = NUM_IDS;
		pool_base = id_t'(1);
		replies_due.delete();
	endtask

	// Work out the reply to one request and update the shadow pool.
	function automatic void serve_request(input logic op, input id_t id_in);
		reply_t r;
		off_t   off;
		id_t    diff;
		r.id = '0;
		if (op == OP_ALLOC) begin
			if (free_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				free_count--;
				off = free_offs[free_count];
				handed_out[off] = 1'b1;
				r.id = id_t'(pool_base + id_t'(off));
				r.status = ST_DONE;
			end
		end else begin
			// The range test wraps modulo 2^16, so an ID below the base is out of range unless base + NUM_IDS wraps past 2^16.
			diff = id_t'(id_in - pool_base);
			off = diff[OFF_W-1:0];
			if (diff >= NUM_IDS || !handed_out[off] || free_count >= NUM_IDS) begin
				r.status = ST_IGNORED;
			end else begin
				handed_out[off] = 1'b0;
				free_offs[free_count] = off;
				free_count++;
				r.status = ST_DONE;
			end
		end
		replies_due.push_back(r);
	endfunction

	// Watch both channels and the register port; replies are retired before new requests.
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			reset_pool();
			replies_owed <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (replies_due.size() == 0) begin
					flag_mismatch($sformatf("reply %h with no request waiting", m_axis_tdata));
				end else begin
					want = replies_due.pop_front();
					if (m_axis_tdata[15:0] !== want.id) begin
						flag_mismatch($sformatf("id_out %h, expected %h",
							m_axis_tdata[15:0], want.id));
					end
					if (m_axis_tdata[17:16] !== want.status) begin
						flag_mismatch($sformatf("status %0d, expected %0d",
							m_axis_tdata[17:16], want.status));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				serve_request(s_axis_tuser[0], s_axis_tdata);
			end
			if (cfg_we) begin
				pool_base = cfg_wdata;
			end
			replies_owed <= replies_due.size();
		end
	end

endmodule

`default_nettype wire

/* verif/id_free_list_allocator_test.sv */
`default_nettype none

module id_free_list_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import idfl_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;    // [15:0] id_in
	logic [0:0]  s_axis_tuser = '0;    // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;         // [15:0] id_out, [17:16] status

	int unsigned mismatch_count;
	int unsigned replies_owed;

	id_t cur_base = id_t'(1);
	int  src_idle_pct = 30;
	int  sink_idle_pct = 30;
	int  sink_hold = 0;

	id_free_list_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	id_pool_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.mismatch_count (mismatch_count),
		.replies_owed   (replies_owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_span();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			return $urandom_range(1, 3);
		end else if (pick < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// The reply side stalls at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
			sink_hold <= idle_span() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Offer one request, after an optional gap, and hold it until it is taken.
	task automatic send_request(input logic op, input id_t id_in);
		int gap;
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			gap = idle_span();
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= id_in;
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Stop offering requests until every reply has come back.
	task automatic wait_for_quiet();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (replies_owed != 0) @(posedge clk);
	endtask

	task automatic set_base(input id_t value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_base = value;
	endtask

	// A mix of allocates and frees; most frees aim at offsets 0 to window above the base.
	task automatic run_mix(input int count, input int window);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_request(OP_ALLOC, id_t'($urandom));
			end else if (pick < 85) begin
				send_request(OP_FREE, id_t'(cur_base + id_t'($urandom_range(0, window))));
			end else if (pick < 93) begin
				send_request(OP_FREE, id_t'($urandom));
			end else if (pick < 97) begin
				send_request(OP_FREE,
					id_t'(cur_base + id_t'(NUM_IDS) + id_t'($urandom_range(0, 3))));
			end else begin
				send_request(OP_FREE, id_t'(cur_base - id_t'($urandom_range(1, 4))));
			end
			if ($urandom_range(0, 99) == 0) begin
				wait_for_quiet();
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests on the reset base: double free, both range edges, wrap below base.
		send_request(OP_ALLOC, 16'hFFFF);
		send_request(OP_ALLOC, 16'h0000);
		send_request(OP_FREE, 16'd1);
		send_request(OP_FREE, 16'd1);
		send_request(OP_FREE, 16'd0);
		send_request(OP_FREE, 16'hFFFF);
		send_request(OP_FREE, id_t'(1 + NUM_IDS));
		send_request(OP_FREE, id_t'(NUM_IDS));
		send_request(OP_ALLOC, 16'h5A5A);
		send_request(OP_FREE, 16'd2);
		send_request(OP_FREE, 16'd1);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);

		// Moving the base also moves the IDs already handed out.
		wait_for_quiet();
		set_base(16'd0);
		send_request(OP_FREE, 16'd0);
		send_request(OP_FREE, 16'd2);
		send_request(OP_FREE, 16'd3);
		send_request(OP_ALLOC, 16'hFFFF);
		send_request(OP_FREE, 16'hFFFF);
		run_mix(300, 48);

		// Highest base, with a slower reply side.
		wait_for_quiet();
		set_base(16'd57344);
		src_idle_pct = 10;
		sink_idle_pct = 40;
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_FREE, 16'hFFFF);
		send_request(OP_FREE, 16'd57343);
		run_mix(300, 48);

		// A long burst at full rate: allocates, then frees, then allocates again.
		wait_for_quiet();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		for (int n = 0; n < 200; n++) begin
			send_request(OP_ALLOC, id_t'($urandom));
		end
		for (int n = 0; n < 40; n++) begin
			send_request(OP_FREE, id_t'(cur_base + id_t'($urandom_range(0, 255))));
		end
		for (int n = 0; n < 20; n++) begin
			send_request(OP_ALLOC, id_t'($urandom));
		end

		// A mix with frees spread over the whole pool on a random base.
		wait_for_quiet();
		set_base(id_t'($urandom_range(1, 57343)));
		src_idle_pct = 30;
		sink_idle_pct = 10;
		run_mix(300, NUM_IDS - 1);

		wait_for_quiet();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && replies_owed == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Give up if the run stalls.
	initial begin
		#4000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
